@@ rtl/kcp_pkg.sv @@
// Shared types and constants for the k-core peeling unit.
package kcp_pkg;

    localparam int NODE_W     = 10;
    localparam int WIDX_W     = 4;
    localparam int DEG_W      = 14;
    localparam int K_W        = 14;
    localparam int NCNT_W     = 11;
    localparam int CORE_W     = 11;
    localparam int MASK_W     = 64;
    localparam int EDGE_W     = 2 * NODE_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 14;
    localparam int S_DATA_W   = 24;
    localparam int S_USER_W   = 2;
    localparam int M_DATA_W   = 80;

    localparam int MAX_NODES_DEF = 1024;
    localparam int MAX_EDGES_DEF = 4096;

    localparam logic [DEG_W-1:0] DEG_MAX = {DEG_W{1'b1}};

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_RUN   = 2'd1,
        ACT_READ  = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_K     = 1'b0,
        CFG_NODES = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        action_t             action;
        logic [NODE_W-1:0]   node_a;
        logic [NODE_W-1:0]   node_b;
        logic [WIDX_W-1:0]   word_index;
    } cmd_t;

    function automatic logic [DEG_W-1:0] deg_inc(input logic [DEG_W-1:0] d);
        deg_inc = (d == DEG_MAX) ? DEG_MAX : d + 1'b1;
    endfunction

endpackage

@@ rtl/kcp_front.sv @@
// Front end: accepts stream transactions, decodes them and queues commands.
module kcp_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [kcp_pkg::S_DATA_W-1:0]  s_tdata,  // node_a, node_b, word_index
    input  logic [kcp_pkg::S_USER_W-1:0]  s_tuser,  // action
    output logic                          cmd_valid,
    output kcp_pkg::cmd_t                 cmd,
    input  logic                          cmd_pop
);
    import kcp_pkg::*;

    localparam int QD = 4;

    cmd_t       q_mem [QD];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] cnt_reg;
    cmd_t       in_cmd;
    logic       push;

    always_comb begin
        in_cmd.action     = action_t'(s_tuser);
        in_cmd.node_a     = s_tdata[9:0];
        in_cmd.node_b     = s_tdata[19:10];
        in_cmd.word_index = s_tdata[23:20];
    end

    assign s_tready  = (cnt_reg != 3'(QD));
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (cnt_reg != 3'd0);
    assign cmd       = q_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (cmd_pop) rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !cmd_pop) cnt_reg <= cnt_reg + 1'b1;
            else if (!push && cmd_pop) cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

@@ rtl/kcp_back.sv @@
// Back end: edge store, peeling sequencer, core bitmap and result register.
module kcp_back #(
    parameter int MAX_NODES = kcp_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = kcp_pkg::MAX_EDGES_DEF,
    parameter int NCW       = $clog2(MAX_NODES + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cmd_valid,
    input  kcp_pkg::cmd_t                 cmd,
    output logic                          cmd_pop,
    input  logic [kcp_pkg::K_W-1:0]       k_threshold,
    input  logic [NCW-1:0]                eff_n,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [kcp_pkg::M_DATA_W-1:0]  m_tdata   // status, core_size, member_mask
);
    import kcp_pkg::*;

    localparam int NIW = $clog2(MAX_NODES);
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW  = (MAX_NODES + 63) / 64;
    localparam int CWW = (CW > 1) ? $clog2(CW) : 1;

    typedef enum logic [19:0] {
        S_IDLE     = 20'h00001,
        S_FIN      = 20'h00002,
        S_READ_W   = 20'h00004,
        S_CLR      = 20'h00008,
        S_E_FETCH  = 20'h00010,
        S_E_CHK    = 20'h00020,
        S_E_INCA   = 20'h00040,
        S_E_RDB    = 20'h00080,
        S_E_INCB   = 20'h00100,
        S_SEED     = 20'h00200,
        S_SEED_CHK = 20'h00400,
        S_P_POP    = 20'h00800,
        S_P_V      = 20'h01000,
        S_P_VCHK   = 20'h02000,
        S_X_FETCH  = 20'h04000,
        S_X_CHK    = 20'h08000,
        S_N_RD     = 20'h10000,
        S_N_UPD    = 20'h20000,
        S_CORE     = 20'h40000,
        S_CORE_CHK = 20'h80000
    } state_t;

    // memories
    logic [EDGE_W-1:0] edge_mem [MAX_EDGES];
    logic [DEG_W-1:0]  rdeg_mem [MAX_NODES];
    logic              qm_mem   [MAX_NODES];
    logic [NIW-1:0]    fifo_mem [MAX_NODES];
    logic [MASK_W-1:0] core_mem [CW];
    logic [CW-1:0]     core_vld_reg;

    logic              edge_we;
    logic [EAW-1:0]    edge_waddr, edge_raddr;
    logic [EDGE_W-1:0] edge_wdata, edge_rdata;
    logic              rdeg_we;
    logic [NIW-1:0]    rdeg_waddr, rdeg_raddr;
    logic [DEG_W-1:0]  rdeg_wdata, rdeg_rdata;
    logic              qm_we, qm_wdata, qm_rdata;
    logic [NIW-1:0]    qm_waddr, qm_raddr;
    logic              fifo_we;
    logic [NIW-1:0]    fifo_waddr, fifo_raddr, fifo_wdata, fifo_rdata;
    logic              core_we;
    logic [CWW-1:0]    core_waddr, core_raddr;
    logic [MASK_W-1:0] core_wdata, core_rdata;
    logic              core_vld_q;

    state_t             state_reg, state_next;
    logic [NCW-1:0]     i_reg, i_next, head_reg, head_next, tail_reg, tail_next;
    logic [NCW-1:0]     cnt_reg, cnt_next, core_total_reg, core_total_next;
    logic [ECW-1:0]     e_reg, e_next, edge_total_reg, edge_total_next;
    logic [NIW-1:0]     v_reg, v_next, u_reg, u_next;
    logic [NODE_W-1:0]  ea_reg, ea_next, eb_reg, eb_next;
    logic               side_reg, side_next, rd_ok_reg, rd_ok_next;
    logic [MASK_W-1:0]  word_reg, word_next, mask_reg, mask_next;
    status_t            status_reg, status_next;
    logic               out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;

    logic [NODE_W-1:0] rd_a, rd_b;
    logic              rd_inr, cbit;
    logic [DEG_W-1:0]  dec;
    logic [MASK_W-1:0] wbuild;
    logic [5:0]        bitpos;

    always_ff @(posedge aclk) begin
        if (edge_we) edge_mem[edge_waddr] <= edge_wdata;
        edge_rdata <= edge_mem[edge_raddr];
        if (rdeg_we) rdeg_mem[rdeg_waddr] <= rdeg_wdata;
        rdeg_rdata <= rdeg_mem[rdeg_raddr];
        if (qm_we) qm_mem[qm_waddr] <= qm_wdata;
        qm_rdata <= qm_mem[qm_raddr];
        if (fifo_we) fifo_mem[fifo_waddr] <= fifo_wdata;
        fifo_rdata <= fifo_mem[fifo_raddr];
        if (core_we) core_mem[core_waddr] <= core_wdata;
        core_rdata <= core_mem[core_raddr];
        core_vld_q <= core_vld_reg[core_raddr];
    end

    assign rd_a   = edge_rdata[NODE_W-1:0];
    assign rd_b   = edge_rdata[EDGE_W-1:NODE_W];
    assign rd_inr = (32'(rd_a) < 32'(eff_n)) && (32'(rd_b) < 32'(eff_n));
    assign dec    = rdeg_rdata - 1'b1;
    assign bitpos = 6'(i_reg);
    assign cbit   = (32'(i_reg) < 32'(eff_n)) && (rdeg_rdata != '0);
    assign wbuild = ((bitpos == 6'd0) ? '0 : word_reg) | (MASK_W'(cbit) << bitpos);

    always_comb begin
        state_next      = state_reg;
        i_next          = i_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        cnt_next        = cnt_reg;
        core_total_next = core_total_reg;
        e_next          = e_reg;
        edge_total_next = edge_total_reg;
        v_next          = v_reg;
        u_next          = u_reg;
        ea_next         = ea_reg;
        eb_next         = eb_reg;
        side_next       = side_reg;
        rd_ok_next      = rd_ok_reg;
        word_next       = word_reg;
        mask_next       = mask_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        cmd_pop         = 1'b0;
        edge_we = 1'b0; edge_waddr = '0; edge_wdata = '0; edge_raddr = '0;
        rdeg_we = 1'b0; rdeg_waddr = '0; rdeg_wdata = '0; rdeg_raddr = '0;
        qm_we   = 1'b0; qm_waddr   = '0; qm_wdata   = 1'b0; qm_raddr = '0;
        fifo_we = 1'b0; fifo_waddr = '0; fifo_wdata = '0; fifo_raddr = '0;
        core_we = 1'b0; core_waddr = '0; core_wdata = '0; core_raddr = '0;

        case (state_reg)
            S_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop     = 1'b1;
                    status_next = ST_OK;
                    mask_next   = '0;
                    case (cmd.action)
                        ACT_ADD: begin
                            if (!((32'(cmd.node_a) < 32'(eff_n)) &&
                                  (32'(cmd.node_b) < 32'(eff_n)))) begin
                                status_next = ST_RANGE;
                            end else if (32'(edge_total_reg) >= 32'(MAX_EDGES)) begin
                                status_next = ST_FULL;
                            end else begin
                                edge_we         = 1'b1;
                                edge_waddr      = edge_total_reg[EAW-1:0];
                                edge_wdata      = {cmd.node_b, cmd.node_a};
                                edge_total_next = edge_total_reg + 1'b1;
                            end
                            state_next = S_FIN;
                        end
                        ACT_RUN: begin
                            i_next     = '0;
                            head_next  = '0;
                            tail_next  = '0;
                            state_next = S_CLR;
                        end
                        ACT_READ: begin
                            rd_ok_next = (32'(cmd.word_index) < 32'(CW));
                            core_raddr = rd_ok_next ? CWW'(cmd.word_index) : '0;
                            state_next = S_READ_W;
                        end
                        ACT_CLEAR: begin
                            edge_total_next = '0;
                            state_next      = S_FIN;
                        end
                        default: state_next = S_FIN;
                    endcase
                end
            end
            S_READ_W: begin
                mask_next  = (rd_ok_reg && core_vld_q) ? core_rdata : '0;
                state_next = S_FIN;
            end
            S_FIN: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = M_DATA_W'({mask_reg, CORE_W'(core_total_reg),
                                                status_reg});
                    state_next     = S_IDLE;
                end
            end
            S_CLR: begin
                rdeg_we    = 1'b1;
                rdeg_waddr = i_reg[NIW-1:0];
                qm_we      = 1'b1;
                qm_waddr   = i_reg[NIW-1:0];
                if (32'(i_reg) == 32'(MAX_NODES - 1)) begin
                    e_next     = '0;
                    state_next = S_E_FETCH;
                end else begin
                    i_next = i_reg + 1'b1;
                end
            end
            S_E_FETCH: begin
                if (e_reg == edge_total_reg) begin
                    i_next     = '0;
                    state_next = S_SEED;
                end else begin
                    edge_raddr = e_reg[EAW-1:0];
                    state_next = S_E_CHK;
                end
            end
            S_E_CHK: begin
                ea_next = rd_a;
                eb_next = rd_b;
                if (rd_inr) begin
                    rdeg_raddr = NIW'(rd_a);
                    state_next = S_E_INCA;
                end else begin
                    e_next     = e_reg + 1'b1;
                    state_next = S_E_FETCH;
                end
            end
            S_E_INCA: begin
                rdeg_we    = 1'b1;
                rdeg_waddr = NIW'(ea_reg);
                rdeg_wdata = deg_inc(rdeg_rdata);
                state_next = S_E_RDB;
            end
            S_E_RDB: begin
                rdeg_raddr = NIW'(eb_reg);
                state_next = S_E_INCB;
            end
            S_E_INCB: begin
                rdeg_we    = 1'b1;
                rdeg_waddr = NIW'(eb_reg);
                rdeg_wdata = deg_inc(rdeg_rdata);
                e_next     = e_reg + 1'b1;
                state_next = S_E_FETCH;
            end
            S_SEED: begin
                if (i_reg == eff_n) begin
                    state_next = S_P_POP;
                end else begin
                    rdeg_raddr = i_reg[NIW-1:0];
                    state_next = S_SEED_CHK;
                end
            end
            S_SEED_CHK: begin
                if (rdeg_rdata < k_threshold) begin
                    qm_we      = 1'b1;
                    qm_waddr   = i_reg[NIW-1:0];
                    qm_wdata   = 1'b1;
                    fifo_we    = 1'b1;
                    fifo_waddr = tail_reg[NIW-1:0];
                    fifo_wdata = i_reg[NIW-1:0];
                    tail_next  = tail_reg + 1'b1;
                end
                i_next     = i_reg + 1'b1;
                state_next = S_SEED;
            end
            S_P_POP: begin
                if (head_reg == tail_reg) begin
                    i_next     = '0;
                    cnt_next   = '0;
                    state_next = S_CORE;
                end else begin
                    fifo_raddr = head_reg[NIW-1:0];
                    head_next  = head_reg + 1'b1;
                    state_next = S_P_V;
                end
            end
            S_P_V: begin
                v_next     = fifo_rdata;
                rdeg_raddr = fifo_rdata;
                state_next = S_P_VCHK;
            end
            S_P_VCHK: begin
                if (rdeg_rdata == '0) begin
                    state_next = S_P_POP;
                end else begin
                    rdeg_we    = 1'b1;
                    rdeg_waddr = v_reg;
                    e_next     = '0;
                    state_next = S_X_FETCH;
                end
            end
            S_X_FETCH: begin
                if (e_reg == edge_total_reg) begin
                    state_next = S_P_POP;
                end else begin
                    edge_raddr = e_reg[EAW-1:0];
                    state_next = S_X_CHK;
                end
            end
            S_X_CHK: begin
                ea_next = rd_a;
                eb_next = rd_b;
                if (rd_inr && (32'(rd_a) == 32'(v_reg))) begin
                    u_next     = NIW'(rd_b);
                    side_next  = 1'b0;
                    state_next = S_N_RD;
                end else if (rd_inr && (32'(rd_b) == 32'(v_reg))) begin
                    u_next     = NIW'(rd_a);
                    side_next  = 1'b1;
                    state_next = S_N_RD;
                end else begin
                    e_next     = e_reg + 1'b1;
                    state_next = S_X_FETCH;
                end
            end
            S_N_RD: begin
                rdeg_raddr = u_reg;
                qm_raddr   = u_reg;
                state_next = S_N_UPD;
            end
            S_N_UPD: begin
                if (rdeg_rdata != '0) begin
                    rdeg_we    = 1'b1;
                    rdeg_waddr = u_reg;
                    rdeg_wdata = dec;
                    if ((dec < k_threshold) && !qm_rdata &&
                        (32'(tail_reg) < 32'(MAX_NODES))) begin
                        qm_we      = 1'b1;
                        qm_waddr   = u_reg;
                        qm_wdata   = 1'b1;
                        fifo_we    = 1'b1;
                        fifo_waddr = tail_reg[NIW-1:0];
                        fifo_wdata = u_reg;
                        tail_next  = tail_reg + 1'b1;
                    end
                end
                // an edge with both ends at v updates the far end twice
                if (!side_reg && (32'(eb_reg) == 32'(v_reg))) begin
                    side_next  = 1'b1;
                    u_next     = NIW'(ea_reg);
                    state_next = S_N_RD;
                end else begin
                    e_next     = e_reg + 1'b1;
                    state_next = S_X_FETCH;
                end
            end
            S_CORE: begin
                rdeg_raddr = i_reg[NIW-1:0];
                state_next = S_CORE_CHK;
            end
            S_CORE_CHK: begin
                word_next = wbuild;
                cnt_next  = cnt_reg + NCW'(cbit);
                if ((bitpos == 6'd63) || (32'(i_reg) == 32'(MAX_NODES - 1))) begin
                    core_we    = 1'b1;
                    core_waddr = CWW'(i_reg >> 6);
                    core_wdata = wbuild;
                end
                if (32'(i_reg) == 32'(MAX_NODES - 1)) begin
                    core_total_next = cnt_reg + NCW'(cbit);
                    state_next      = S_FIN;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_CORE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        i_reg        <= i_next;
        head_reg     <= head_next;
        tail_reg     <= tail_next;
        cnt_reg      <= cnt_next;
        e_reg        <= e_next;
        v_reg        <= v_next;
        u_reg        <= u_next;
        ea_reg       <= ea_next;
        eb_reg       <= eb_next;
        side_reg     <= side_next;
        rd_ok_reg    <= rd_ok_next;
        word_reg     <= word_next;
        mask_reg     <= mask_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            edge_total_reg <= '0;
            core_total_reg <= '0;
            out_valid_reg  <= 1'b0;
            core_vld_reg   <= '0;
        end else begin
            state_reg      <= state_next;
            edge_total_reg <= edge_total_next;
            core_total_reg <= core_total_next;
            out_valid_reg  <= out_valid_next;
            if (core_we) core_vld_reg[core_waddr] <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ rtl/k_core_peeling_unit.sv @@
// Top level of the k-core peeling unit: configuration registers, front and back ends.
// Holds an undirected edge list and finds the k-core by peeling. Each input
// transaction (action in s_tuser) yields exactly one result transaction.
// Edge add, clear and membership read are handled by the back-end
// sequencer. A run walks the graph with one read port per store: it clears
// the working degrees of all MAX_NODES entries, counts degrees over the
// stored edges with both endpoints in range, seeds the work queue with the
// in-range nodes below k, then for each queued node with degree left scans
// every stored edge and updates each incident edge end, and finally builds
// the membership bitmap. A 4-entry command queue lets the front keep taking
// transactions while the back end works, and a result register holds the
// finished result until m_tready. The user must write k_threshold and
// node_count through cfg_we/cfg_index/cfg_data only while the unit is idle;
// the block itself does not enforce it. node_count above MAX_NODES acts as
// MAX_NODES. Edge store state is undefined after reset until written; edge
// count and the core bitmap reset to empty.
module k_core_peeling_unit #(
    parameter int MAX_NODES = kcp_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = kcp_pkg::MAX_EDGES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [kcp_pkg::S_DATA_W-1:0]    s_tdata,  // node_a[9:0], node_b[19:10], word_index[23:20]
    input  logic [kcp_pkg::S_USER_W-1:0]    s_tuser,  // action[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [kcp_pkg::M_DATA_W-1:0]    m_tdata,  // status[1:0], core_size[12:2], member_mask[76:13]
    input  logic                            cfg_we,
    input  logic [kcp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kcp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import kcp_pkg::*;

    localparam int NCW = $clog2(MAX_NODES + 1);

    logic [K_W-1:0]    k_reg;
    logic [NCNT_W-1:0] ncnt_reg;
    logic [NCW-1:0]    eff_n;
    logic              cmd_valid, cmd_pop;
    cmd_t              cmd;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg    <= '0;
            ncnt_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_K:     k_reg    <= cfg_data[K_W-1:0];
                CFG_NODES: ncnt_reg <= cfg_data[NCNT_W-1:0];
                default:   ;
            endcase
        end
    end

    // clamp node count to the storage depth
    assign eff_n = (32'(ncnt_reg) > 32'(MAX_NODES)) ? NCW'(MAX_NODES) : NCW'(ncnt_reg);

    kcp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    kcp_back #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES),
        .NCW       (NCW)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop),
        .k_threshold (k_reg),
        .eff_n       (eff_n),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

@@ dv/tb_k_core_peeling_unit.sv @@
// Self-checking testbench for the k-core peeling unit.
module tb_k_core_peeling_unit;
    import kcp_pkg::*;

    localparam int NNODES = MAX_NODES_DEF;
    localparam int NEDGES = MAX_EDGES_DEF;
    localparam int CYCLE_LIMIT = 6000000;

    typedef struct packed {
        status_t           status;
        logic [CORE_W-1:0] core_size;
        logic [MASK_W-1:0] mask;
    } core_result_t;

    // Scoreboard: mirrors the graph and core state, queues the expected results.
    class core_scoreboard;
        logic [K_W-1:0]    k_thr;
        logic [NCNT_W-1:0] n_cfg;
        logic [NODE_W-1:0] edge_a[$];
        logic [NODE_W-1:0] edge_b[$];
        bit                in_core[NNODES];
        int                core_count;
        core_result_t      expected_q[$];
        int                errors;

        function new();
            k_thr = '0;
            n_cfg = '0;
            core_count = 0;
            errors = 0;
            foreach (in_core[i]) in_core[i] = 1'b0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_K) k_thr = val[K_W-1:0];
            else n_cfg = val[NCNT_W-1:0];
        endfunction

        function int nodes_in_use();
            return (n_cfg > NNODES) ? NNODES : int'(n_cfg);
        endfunction

        // Peel all nodes whose degree drops below k; survivors with edges form the core.
        function void peel();
            int n, v, u, head;
            int deg[NNODES];
            bit queued[NNODES];
            int work_q[$];
            n = nodes_in_use();
            head = 0;
            foreach (deg[i]) begin
                deg[i] = 0;
                queued[i] = 1'b0;
            end
            foreach (edge_a[e]) begin
                if (edge_a[e] < n && edge_b[e] < n) begin
                    if (deg[edge_a[e]] < int'(DEG_MAX)) deg[edge_a[e]]++;
                    if (deg[edge_b[e]] < int'(DEG_MAX)) deg[edge_b[e]]++;
                end
            end
            for (int i = 0; i < n; i++) begin
                if (deg[i] < k_thr) begin
                    queued[i] = 1'b1;
                    work_q.insert(work_q.size(), i);
                end
            end
            while (head < work_q.size()) begin
                v = work_q[head];
                head++;
                if (deg[v] == 0) continue;
                deg[v] = 0;
                foreach (edge_a[e]) begin
                    if (edge_a[e] >= n || edge_b[e] >= n) continue;
                    for (int side = 0; side < 2; side++) begin
                        if (side == 0 && edge_a[e] != v) continue;
                        if (side == 1 && edge_b[e] != v) continue;
                        u = (side == 0) ? edge_b[e] : edge_a[e];
                        if (deg[u] > 0) begin
                            deg[u]--;
                            if (deg[u] < k_thr && !queued[u]) begin
                                queued[u] = 1'b1;
                                work_q.insert(work_q.size(), u);
                            end
                        end
                    end
                end
            end
            core_count = 0;
            for (int i = 0; i < NNODES; i++) begin
                in_core[i] = (i < n) && (deg[i] > 0);
                core_count += in_core[i];
            end
        endfunction

        // Accepted input transaction: update the mirror and queue the result.
        function void note_input(action_t act, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                                 logic [WIDX_W-1:0] w);
            core_result_t r;
            r.status = ST_OK;
            r.mask = '0;
            case (act)
                ACT_ADD: begin
                    if (a >= nodes_in_use() || b >= nodes_in_use()) r.status = ST_RANGE;
                    else if (edge_a.size() >= NEDGES) r.status = ST_FULL;
                    else begin
                        edge_a.insert(edge_a.size(), a);
                        edge_b.insert(edge_b.size(), b);
                    end
                end
                ACT_RUN: peel();
                ACT_READ: begin
                    for (int i = 0; i < 64; i++)
                        r.mask[i] = in_core[int'(w) * 64 + i];
                end
                default: begin
                    edge_a.delete();
                    edge_b.delete();
                end
            endcase
            r.core_size = core_count[CORE_W-1:0];
            expected_q.insert(expected_q.size(), r);
        endfunction

        function void check_result(logic [M_DATA_W-1:0] d);
            core_result_t exp_r;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, d);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (d[1:0] != exp_r.status) begin
                $display("%0t: status exp %0d got %0d", $time, exp_r.status, d[1:0]);
                errors++;
            end
            if (d[12:2] != exp_r.core_size) begin
                $display("%0t: core_size exp %0d got %0d", $time, exp_r.core_size, d[12:2]);
                errors++;
            end
            if (d[76:13] != exp_r.mask) begin
                $display("%0t: member_mask exp %h got %h", $time, exp_r.mask, d[76:13]);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic [S_USER_W-1:0]   s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    core_scoreboard score = new();
    bit  idle_on = 1'b1;        // random gaps on both sides
    bit  long_hold_req = 1'b0;  // asks the receiver for one long stall
    int  cycle_count = 0;

    k_core_peeling_unit dut (.*);

    always #5 aclk = ~aclk;

    // Cycle limit: a hang or lost result ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off that backs up the command queue.
    initial begin
        @(posedge aclk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) score.check_result(m_tdata);
    end

    // One input transaction; returns after the handshake edge.
    task automatic send(action_t act, int a = 0, int b = 0, int w = 0);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {w[WIDX_W-1:0], b[NODE_W-1:0], a[NODE_W-1:0]};
        do @(posedge aclk); while (!s_tready);
        score.note_input(act, a[NODE_W-1:0], b[NODE_W-1:0], w[WIDX_W-1:0]);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (score.expected_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    // Register write, only with the unit drained.
    task automatic set_reg(cfg_idx_t idx, int val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge aclk);
        score.write_reg(idx, val[CFG_DATA_W-1:0]);
        cfg_we <= 1'b0;
    endtask

    task automatic read_all(int n);
        for (int w = 0; w <= (n - 1) / 64 && w < 16; w++) send(ACT_READ, 0, 0, w);
    endtask

    int n_sel, k_sel, n_edges, hi, items;

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty core reads, top-end nodes, self loop, clear keeps the core.
        send(ACT_READ, 0, 0, 0);
        set_reg(CFG_K, 2);
        set_reg(CFG_NODES, 2047);   // above the node limit: acts as full size
        send(ACT_ADD, 0, 1);
        send(ACT_ADD, 1, 2);
        send(ACT_ADD, 2, 0);
        send(ACT_ADD, 5, 5);
        send(ACT_ADD, 3, 4);
        send(ACT_ADD, 1023, 1022);
        send(ACT_ADD, 1022, 1021);
        send(ACT_ADD, 1021, 1023);
        send(ACT_RUN);
        send(ACT_READ, 0, 0, 0);
        send(ACT_READ, 0, 0, 15);
        send(ACT_CLEAR);
        send(ACT_READ, 0, 0, 15);
        send(ACT_RUN);
        // Zero threshold and out-of-range endpoints.
        set_reg(CFG_K, 0);
        set_reg(CFG_NODES, 8);
        send(ACT_ADD, 0, 1);
        send(ACT_ADD, 9, 1);
        send(ACT_ADD, 1, 8);
        send(ACT_RUN);
        send(ACT_READ, 0, 0, 0);
        set_reg(CFG_NODES, 0);
        send(ACT_ADD, 0, 0);
        send(ACT_RUN);
        // Largest threshold peels everything.
        set_reg(CFG_K, 16383);
        set_reg(CFG_NODES, 16);
        send(ACT_ADD, 0, 15);
        send(ACT_RUN);
        // Node count lowered after loading.
        set_reg(CFG_K, 1);
        set_reg(CFG_NODES, 10);
        send(ACT_RUN);
        send(ACT_READ, 0, 0, 0);

        // Random phases: load a small graph, peel, read back.
        items = 0;
        for (int ph = 0; items < 1400; ph++) begin
            if (items >= 1150) idle_on = 1'b0;   // last stretch runs without gaps
            n_sel = $urandom_range(0, 9);
            if (n_sel == 0) n_sel = $urandom_range(0, 2047);
            else if (n_sel == 1) n_sel = 1024;
            else n_sel = $urandom_range(2, 64);
            k_sel = $urandom_range(0, 9);
            if (k_sel == 9) k_sel = $urandom_range(0, 16383);
            else if (k_sel > 5) k_sel = $urandom_range(1, 4);
            set_reg(CFG_NODES, n_sel);
            set_reg(CFG_K, k_sel);
            if ($urandom_range(0, 2) != 0) begin
                send(ACT_CLEAR);
                items++;
            end
            hi = (n_sel > 1024) ? 1023 : (n_sel < 16 ? 15 : n_sel - 1);
            n_edges = $urandom_range(0, 60);
            for (int e = 0; e < n_edges; e++) begin
                if ($urandom_range(0, 9) == 0)
                    send(ACT_ADD, $urandom_range(0, 1023), $urandom_range(0, 1023));
                else
                    send(ACT_ADD, $urandom_range(0, hi), $urandom_range(0, hi));
                items++;
            end
            if ($urandom_range(0, 7) == 0 && n_sel > 2)
                set_reg(CFG_NODES, $urandom_range(0, n_sel - 1));
            send(ACT_RUN);
            items++;
            if (ph == 5) begin
                // Long receiver stall while reads keep coming: queue fills, input stalls.
                long_hold_req = 1'b1;
                for (int i = 0; i < 12; i++) send(ACT_READ, 0, 0, $urandom_range(0, 15));
                items += 12;
            end
            read_all((n_sel > 1024) ? 1024 : n_sel);
            send(ACT_READ, 0, 0, $urandom_range(0, 15));
            items += 4;
        end

        drain();
        repeat (50) @(posedge aclk);
        if (score.errors == 0 && score.expected_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/kcp_pkg.sv
rtl/kcp_front.sv
rtl/kcp_back.sv
rtl/k_core_peeling_unit.sv
dv/tb_k_core_peeling_unit.sv
